/* hdl/lbc_pkg.sv */
// lbc_pkg: types and codes for the LRU block cache tag store.
// No dependencies.
package lbc_pkg;
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_DONE  = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  localparam logic [2:0] ACT_BYPASS = 3'd0;
  localparam logic [2:0] ACT_SERVE  = 3'd1;
  localparam logic [2:0] ACT_FETCH  = 3'd2;
  localparam logic [2:0] ACT_FLUSH  = 3'd3;
  localparam logic [2:0] ACT_ABSORB = 3'd4;
  localparam logic [2:0] ACT_DONE   = 3'd5;

  localparam logic CFG_BSL2 = 1'b0;
  localparam logic CFG_BLKS = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT,
    ST_WRITE,
    ST_OUT
  } state_t;
endpackage

/* hdl/lru_block_cache_pending_core.sv */
// lru_block_cache_pending_core: top level of the LRU block cache tag store.
// Uses lbc_pkg.
//
// channel  ports                                      dir  handshake
// in       in_operation in_file_id in_byte_offset     in   start & !busy
// out      out_action out_hit out_evicted ...         out  out_valid, 1 cycle
// cfg      cfg_we cfg_index cfg_wdata                 in   cfg_we
//
// A request holds busy for at most two passes: one pass reads the order memory
// and tags (one position a cycle, the tag read addressed by the registered
// order read), a second pass shifts the recency order one position a cycle.
// The block returns to idle after each result. Sync reset clears control state
// and the pending bits; no clearing pass. The receiver cannot stall: out_valid
// is high one cycle per result.
module lru_block_cache_pending_core #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [15:0] in_file_id,
  input  logic [31:0] in_byte_offset,
  output logic        out_valid,
  output logic [2:0]  out_action,
  output logic        out_hit,
  output logic        out_evicted,
  output logic        out_cache_full,
  output logic        out_flush_now,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_wdata
);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [15:0] file_mem [CAPACITY];
  logic [31:0] blk_mem  [CAPACITY];
  logic [AW-1:0] ord_mem [CAPACITY];
  logic [CAPACITY-1:0] pend_r;

  lbc_pkg::state_t st_r, st_nxt;
  logic [4:0] bsl2_r;
  logic [6:0] blks_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [1:0] op_r;
  logic [15:0] file_r;
  logic [31:0] blk_r;
  logic [CW-1:0] pos_r, pos_nxt;
  logic rd_v_r, rd_v_nxt;
  logic [CW-1:0] rd_pos_r, rd_pos_nxt;
  logic hit_r, hit_nxt;
  logic [CW-1:0] hpos_r, hpos_nxt;
  logic [AW-1:0] hslot_r, hslot_nxt;
  logic allp_r, allp_nxt;
  logic [AW-1:0] ord_q;
  logic [15:0] file_q;
  logic [31:0] blk_q;
  logic [CW-1:0] last_r, last_nxt;
  logic [AW-1:0] nslot_r, nslot_nxt;
  logic do_ins_r, do_ins_nxt;
  logic ev_r, ev_nxt;
  logic [2:0] act_r, act_nxt;
  logic fnow_r, fnow_nxt;
  logic [CW-1:0] limit;

  logic ord_we;
  logic [AW-1:0] ord_wa, ord_wd, ord_ra;
  logic tag_we;
  logic [AW-1:0] tag_ra;
  logic [CW-1:0] sh_pos_r, sh_pos_nxt;
  logic sh_rd_r, sh_rd_nxt;

  always_comb begin
    if (blks_r == 7'd0) limit = CW'(1);
    else if (32'(blks_r) > 32'(CAPACITY)) limit = CW'(CAPACITY);
    else limit = CW'(blks_r);
  end

  always_ff @(posedge clk) begin
    if (ord_we) ord_mem[ord_wa] <= ord_wd;
    ord_q <= ord_mem[ord_ra];
    if (tag_we) begin
      file_mem[nslot_r] <= file_r;
      blk_mem[nslot_r]  <= blk_r;
    end
    file_q <= file_mem[tag_ra];
    blk_q  <= blk_mem[tag_ra];
  end

  // tag read is addressed by the registered order read, so it follows it in the next cycle
  assign tag_ra = ord_q;

  logic tag_v_r;
  logic [CW-1:0] tag_pos_r;
  logic [AW-1:0] tag_slot_r;

  logic scan_done;
  assign scan_done = !rd_v_r && !tag_v_r && (pos_r >= count_r);

  always_comb begin
    st_nxt = st_r;
    count_nxt = count_r;
    pos_nxt = pos_r;
    rd_v_nxt = 1'b0;
    rd_pos_nxt = rd_pos_r;
    hit_nxt = hit_r;
    hpos_nxt = hpos_r;
    hslot_nxt = hslot_r;
    allp_nxt = allp_r;
    last_nxt = last_r;
    nslot_nxt = nslot_r;
    do_ins_nxt = do_ins_r;
    ev_nxt = ev_r;
    act_nxt = act_r;
    fnow_nxt = fnow_r;
    ord_we = 1'b0;
    ord_wa = '0;
    ord_wd = '0;
    ord_ra = pos_r[AW-1:0];
    tag_we = 1'b0;
    sh_pos_nxt = sh_pos_r;
    sh_rd_nxt = 1'b0;
    case (st_r)
      lbc_pkg::ST_IDLE: begin
        pos_nxt = '0;
        hit_nxt = 1'b0;
        allp_nxt = 1'b1;
        ev_nxt = 1'b0;
        fnow_nxt = 1'b0;
        do_ins_nxt = 1'b0;
        if (start && in_operation != lbc_pkg::OP_NOP) st_nxt = lbc_pkg::ST_SCAN;
      end
      lbc_pkg::ST_SCAN: begin
        if (!hit_r && pos_r < count_r) begin
          ord_ra = pos_r[AW-1:0];
          rd_v_nxt = 1'b1;
          rd_pos_nxt = pos_r;
          pos_nxt = pos_r + CW'(1);
        end else if (!hit_r) begin
          ord_ra = pos_r[AW-1:0];
        end
        if (tag_v_r) begin
          if (!pend_r[tag_slot_r]) allp_nxt = 1'b0;
          if (!hit_r && file_q == file_r && blk_q == blk_r) begin
            hit_nxt = 1'b1;
            hpos_nxt = tag_pos_r;
            hslot_nxt = tag_slot_r;
          end
        end
        if (hit_nxt && !hit_r) begin
          // stop issuing; drain nothing more
          rd_v_nxt = 1'b0;
          st_nxt = lbc_pkg::ST_DECIDE;
        end else if (scan_done) st_nxt = lbc_pkg::ST_DECIDE;
      end
      lbc_pkg::ST_DECIDE: begin
        // allp is only complete when no hit; hit never bypasses
        st_nxt = lbc_pkg::ST_OUT;
        if (op_r == lbc_pkg::OP_DONE) begin
          act_nxt = lbc_pkg::ACT_DONE;
          if (hit_r) st_nxt = lbc_pkg::ST_SHIFT;
        end else if ((count_r >= limit) && allp_r && (count_r != '0) && !hit_r) begin
          act_nxt = lbc_pkg::ACT_BYPASS;
        end else if (op_r == lbc_pkg::OP_READ) begin
          if (hit_r) begin
            act_nxt = lbc_pkg::ACT_SERVE;
            if (!pend_r[hslot_r]) st_nxt = lbc_pkg::ST_SHIFT;
          end else begin
            act_nxt = lbc_pkg::ACT_FETCH;
            do_ins_nxt = 1'b1;
            st_nxt = lbc_pkg::ST_SHIFT;
          end
        end else begin
          if (hit_r && pend_r[hslot_r]) act_nxt = lbc_pkg::ACT_ABSORB;
          else begin
            act_nxt = lbc_pkg::ACT_FLUSH;
            do_ins_nxt = !hit_r;
            st_nxt = lbc_pkg::ST_SHIFT;
          end
        end
        // set up shift: positions last..1 take position-1
        if (hit_r) last_nxt = hpos_r;
        else if (count_r >= limit && count_r != '0) last_nxt = count_r - CW'(1);
        else last_nxt = count_r;
        if (!hit_r && st_nxt == lbc_pkg::ST_SHIFT && count_r >= CW'(CAPACITY)
            && !(count_r >= limit)) st_nxt = lbc_pkg::ST_OUT;
        sh_pos_nxt = last_nxt;
        ord_ra = last_nxt[AW-1:0];
        sh_rd_nxt = 1'b1;
      end
      lbc_pkg::ST_SHIFT: begin
        // ord_q holds entry at sh_pos_r (read last cycle)
        if (sh_rd_r) begin
          if (sh_pos_r == last_r) begin
            if (hit_r) nslot_nxt = hslot_r;
            else if (last_r != count_r) begin
              nslot_nxt = ord_q;
              ev_nxt = 1'b1;
            end else nslot_nxt = count_r[AW-1:0];
          end else begin
            ord_we = 1'b1;
            ord_wa = AW'(sh_pos_r + CW'(1));
            ord_wd = ord_q;
          end
          if (sh_pos_r == '0) begin
            st_nxt = lbc_pkg::ST_WRITE;
          end else begin
            sh_pos_nxt = sh_pos_r - CW'(1);
            ord_ra = AW'(sh_pos_r - CW'(1));
            sh_rd_nxt = 1'b1;
          end
        end else st_nxt = lbc_pkg::ST_WRITE;
        if (sh_rd_r && sh_pos_r == last_r && last_r == '0 && !hit_r
            && last_r == count_r) nslot_nxt = '0;
      end
      lbc_pkg::ST_WRITE: begin
        ord_we = 1'b1;
        ord_wa = '0;
        ord_wd = nslot_r;
        tag_we = do_ins_r;
        if (do_ins_r && !ev_r) count_nxt = count_r + CW'(1);
        if (act_r == lbc_pkg::ACT_FLUSH) fnow_nxt = (count_nxt >= limit);
        st_nxt = lbc_pkg::ST_OUT;
      end
      lbc_pkg::ST_OUT: st_nxt = lbc_pkg::ST_IDLE;
      default: st_nxt = lbc_pkg::ST_IDLE;
    endcase
  end

  // when count is zero the shift pass reads position 0 which holds garbage;
  // last==count==0 path handled by nslot=count above

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= lbc_pkg::ST_IDLE;
      count_r <= '0;
      pend_r <= '0;
      bsl2_r <= 5'd12;
      blks_r <= 7'd64;
      tag_v_r <= 1'b0;
      rd_v_r <= 1'b0;
      sh_rd_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      count_r <= count_nxt;
      rd_v_r <= rd_v_nxt;
      tag_v_r <= rd_v_r && !hit_nxt && (st_r == lbc_pkg::ST_SCAN);
      sh_rd_r <= sh_rd_nxt;
      if (cfg_we) begin
        if (cfg_index == lbc_pkg::CFG_BSL2) bsl2_r <= cfg_wdata[4:0];
        else blks_r <= cfg_wdata;
      end
      if (st_r == lbc_pkg::ST_WRITE) begin
        if (do_ins_r) pend_r[nslot_r] <= 1'b1;
        else if (op_r == lbc_pkg::OP_DONE) pend_r[nslot_r] <= 1'b0;
        else if (op_r == lbc_pkg::OP_WRITE) pend_r[nslot_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == lbc_pkg::ST_IDLE && start) begin
      op_r <= in_operation;
      file_r <= in_file_id;
      blk_r <= in_byte_offset >> bsl2_r;
    end
    pos_r <= pos_nxt;
    rd_pos_r <= rd_pos_nxt;
    tag_pos_r <= rd_pos_r;
    tag_slot_r <= ord_q;
    hit_r <= hit_nxt;
    hpos_r <= hpos_nxt;
    hslot_r <= hslot_nxt;
    allp_r <= allp_nxt;
    last_r <= last_nxt;
    nslot_r <= nslot_nxt;
    do_ins_r <= do_ins_nxt;
    ev_r <= ev_nxt;
    act_r <= act_nxt;
    fnow_r <= fnow_nxt;
    sh_pos_r <= sh_pos_nxt;
  end

  assign busy = (st_r != lbc_pkg::ST_IDLE);
  assign out_valid = (st_r == lbc_pkg::ST_OUT);
  assign out_action = act_r;
  assign out_hit = hit_r;
  assign out_evicted = ev_r;
  assign out_cache_full = (count_r >= limit);
  assign out_flush_now = fnow_r;
endmodule
